FILE: src/ffha_pkg.sv
// types, constants and codes for the first-fit heap allocator
// used by the top level and the port checker
`default_nettype none

package ffha_pkg;

  localparam int HEAP_BYTES   = 4096;
  localparam int HEADER_BYTES = 24;
  localparam int MAX_CHUNKS   = 256;

  // widths fixed by the item fields
  localparam int REQ_W = 13;
  localparam int OFF_W = 12;

  // widths derived from the heap geometry
  localparam int ADDR_W = $clog2(HEAP_BYTES);
  localparam int IDX_W  = $clog2(MAX_CHUNKS);
  localparam int LINK_W = $clog2(MAX_CHUNKS + 1);
  localparam int CMP_W  = ((ADDR_W > REQ_W) ? ADDR_W : REQ_W) + 2;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_ZERO    = 2'd1,
    STAT_NOFIT   = 2'd2,
    STAT_BADFREE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_FETCH,
    S_CHECK,
    S_UPDATE
  } state_e;

  typedef struct packed {
    mode_e              mode;
    logic [REQ_W-1:0]   request_bytes;
    logic [OFF_W-1:0]   payload_offset;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic [OFF_W-1:0]   block_offset;
  } result_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  start;
    logic [ADDR_W-1:0]  size;
    logic               is_free;
    logic [LINK_W-1:0]  link;
  } chunk_t;

endpackage

`default_nettype wire

FILE: src/ffha_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: src/first_fit_heap_allocator.sv
// first-fit heap allocator top level: sequencer, chunk table and result register
// depends on ffha_pkg and ffha_ram
`default_nettype none

// Usage
//   An item (mode, request_bytes, payload_offset) is taken at a rising edge
//   with start high and busy low. An allocate item walks the chunk list from
//   the head for the first free chunk big enough, splitting it when the rest
//   can hold a header and at least one byte and a table entry is unused.
//   A free item walks the list for the chunk with that payload offset and
//   marks it free. Each item gives exactly one result (status,
//   block_offset), shown for one cycle with result_valid_o high. The
//   receiver cannot stall it. A zero-size allocate or a null free answers
//   on the next cycle. Otherwise each chunk visited is read in S_FETCH
//   (ram read address), then compared in S_CHECK on the registered read
//   data; a split adds S_UPDATE, and the result is registered.
//   busy is high for the whole walk; a new item may be taken in the cycle
//   its predecessor's result is shown.
//   Reset: after rst_ni rises the block writes the single free chunk into
//   table entry 0 in state S_INIT, with busy high, before taking items.

module first_fit_heap_allocator (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  input  wire ffha_pkg::item_t req_i,
  output logic                 busy,
  output logic                 result_valid_o,
  output ffha_pkg::result_t    result_o
);

  import ffha_pkg::*;

  state_e            state_q, state_d;
  item_t             item_q, item_d;
  logic [LINK_W-1:0] cur_q, cur_d;
  logic [LINK_W-1:0] used_q, used_d;
  chunk_t            ent_q, ent_d;
  logic              res_valid_q, res_valid_d;
  result_t           res_q, res_d;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  chunk_t            ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  chunk_t            ram_rdata;

  ffha_ram #(
    .WIDTH($bits(chunk_t)),
    .DEPTH(MAX_CHUNKS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // shared compare/add datapath on the current chunk
  logic [CMP_W-1:0] size_x, req_x, pay_x, off_x, rest_x;
  logic             fits, can_split, off_match;

  always_comb begin
    size_x    = CMP_W'(ram_rdata.size);
    req_x     = CMP_W'(item_q.request_bytes);
    pay_x     = CMP_W'(ram_rdata.start) + CMP_W'(HEADER_BYTES);
    off_x     = CMP_W'(item_q.payload_offset);
    rest_x    = req_x + CMP_W'(HEADER_BYTES + 1);
    fits      = ram_rdata.is_free && (size_x >= req_x);
    can_split = (size_x >= rest_x) && (used_q < LINK_W'(MAX_CHUNKS));
    off_match = (pay_x == off_x);
  end

  logic [CMP_W-1:0] upd_pay_x;
  assign upd_pay_x = CMP_W'(ent_q.start) + CMP_W'(HEADER_BYTES);

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    cur_d       = cur_q;
    used_d      = used_q;
    ent_d       = ent_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = ram_rdata;
    ram_raddr   = cur_q[IDX_W-1:0];

    case (state_q)
      S_INIT: begin
        ram_we            = 1'b1;
        ram_waddr         = '0;
        ram_wdata.start   = '0;
        ram_wdata.size    = ADDR_W'(HEAP_BYTES - HEADER_BYTES);
        ram_wdata.is_free = 1'b1;
        ram_wdata.link    = LINK_W'(MAX_CHUNKS);
        used_d            = LINK_W'(1);
        state_d           = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          item_d = req_i;
          cur_d  = '0;
          if (req_i.mode == MODE_ALLOC && req_i.request_bytes == '0) begin
            res_valid_d = 1'b1;
            res_d       = '{status: STAT_ZERO, block_offset: '0};
          end else if (req_i.mode == MODE_FREE && req_i.payload_offset == '0) begin
            res_valid_d = 1'b1;
            res_d       = '{status: STAT_OK, block_offset: '0};
          end else begin
            state_d = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        // link beyond the table (including null) ends the walk
        if (cur_q >= used_q) begin
          res_valid_d = 1'b1;
          res_d.status = (item_q.mode == MODE_ALLOC) ? STAT_NOFIT : STAT_BADFREE;
          res_d.block_offset = '0;
          state_d = S_IDLE;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        ent_d = ram_rdata;
        if (item_q.mode == MODE_ALLOC) begin
          if (fits) begin
            if (can_split) begin
              // new free remainder goes in the next unused entry
              ram_we            = 1'b1;
              ram_waddr         = used_q[IDX_W-1:0];
              ram_wdata.start   = ADDR_W'(pay_x + req_x);
              ram_wdata.size    = ADDR_W'(size_x - req_x - CMP_W'(HEADER_BYTES));
              ram_wdata.is_free = 1'b1;
              ram_wdata.link    = ram_rdata.link;
              state_d           = S_UPDATE;
            end else begin
              ram_we            = 1'b1;
              ram_waddr         = cur_q[IDX_W-1:0];
              ram_wdata.is_free = 1'b0;
              res_valid_d       = 1'b1;
              res_d.status      = STAT_OK;
              res_d.block_offset = OFF_W'(pay_x);
              state_d           = S_IDLE;
            end
          end else begin
            cur_d   = ram_rdata.link;
            state_d = S_FETCH;
          end
        end else begin
          if (off_match) begin
            ram_we             = 1'b1;
            ram_waddr          = cur_q[IDX_W-1:0];
            ram_wdata.is_free  = 1'b1;
            res_valid_d        = 1'b1;
            res_d              = '{status: STAT_OK, block_offset: '0};
            state_d            = S_IDLE;
          end else begin
            cur_d   = ram_rdata.link;
            state_d = S_FETCH;
          end
        end
      end
      S_UPDATE: begin
        ram_we             = 1'b1;
        ram_waddr          = cur_q[IDX_W-1:0];
        ram_wdata.start    = ent_q.start;
        ram_wdata.size     = ADDR_W'(item_q.request_bytes);
        ram_wdata.is_free  = 1'b0;
        ram_wdata.link     = used_q;
        used_d             = used_q + LINK_W'(1);
        res_valid_d        = 1'b1;
        res_d.status       = STAT_OK;
        res_d.block_offset = OFF_W'(upd_pay_x);
        state_d            = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      used_q      <= LINK_W'(1);
      cur_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      cur_q       <= cur_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    ent_q  <= ent_d;
    res_q  <= res_d;
  end

endmodule

`default_nettype wire

FILE: src/ffha_checker.sv
// port-level checks for the first-fit heap allocator, bound to the top level
// depends on ffha_pkg and first_fit_heap_allocator
`default_nettype none

module ffha_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire ffha_pkg::item_t   req_i,
  input wire logic              busy,
  input wire logic              result_valid_o,
  input wire ffha_pkg::result_t result_o
);

  import ffha_pkg::*;

  // an accepted item either starts a walk or answers at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || result_valid_o))
    else $error("accepted item neither walked nor answered");

  // a result only follows an accepted item or a walk
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(busy) || $past(start)))
    else $error("result with no item behind it");

  // failures carry no block offset (free items also answer with a zero offset)
  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status != STAT_OK) |-> (result_o.block_offset == '0))
    else $error("nonzero offset on a failed item");

  // a zero-size allocate answers on the next cycle
  a_zero_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.mode == MODE_ALLOC && req_i.request_bytes == '0)
    |=> (result_valid_o && result_o.status == STAT_ZERO && !busy))
    else $error("zero-size allocate not answered at once");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .req_i         (req_i),
  .busy          (busy),
  .result_valid_o(result_valid_o),
  .result_o      (result_o)
);

`default_nettype wire
